// ===== sv/s2d_pkg.sv =====
// Package for the speed-to-duty interpolator: item type, table sizes and the
// constant speed, duty and slope tables. No dependencies.
`default_nettype none
package s2d_pkg;

  localparam int ROM_CAP    = 64;   // table capacity
  localparam int ROM_FILLED = 17;   // points defined in the tables
  localparam int SEG_W      = 6;    // segment index width for ROM_CAP points
  localparam int SPEED_W    = 16;   // input speed width
  localparam int ABS_W      = 17;   // magnitude of a 16-bit signed speed
  localparam int X_W        = 10;   // width of a speed table entry
  localparam int DS_W       = 7;    // offset into a segment (widest is 82)
  localparam int DUTY_W     = 14;   // output duty width
  localparam int MAG_W      = 15;   // magnitude, same width as the limit
  localparam int FRAC       = 16;   // fraction bits of the slope table
  localparam int SLOPE_W    = 21;
  localparam int PROD_W     = DS_W + SLOPE_W;
  localparam int Q_W        = PROD_W - FRAC;
  localparam int SLOPE_NUM  = 500 * (2 ** FRAC);  // duty step of 500 per segment
  localparam logic [MAG_W-1:0] LIMIT_RESET = 15'd10000;

  // Speed points in tenths of a unit.
  localparam logic [X_W-1:0] SPEED_ROM [ROM_CAP] = '{
    0: 10'd0,    1: 10'd54,   2: 10'd130,  3: 10'd184,
    4: 10'd222,  5: 10'd276,  6: 10'd342,  7: 10'd380,
    8: 10'd458,  9: 10'd496,  10: 10'd572, 11: 10'd648,
    12: 10'd678, 13: 10'd760, 14: 10'd818, 15: 10'd884,
    16: 10'd938, default: 10'd0
  };

  localparam logic [DUTY_W-1:0] DUTY_ROM [ROM_CAP] = '{
    0: 14'd0,     1: 14'd500,   2: 14'd1000,  3: 14'd1500,
    4: 14'd2000,  5: 14'd2500,  6: 14'd3000,  7: 14'd3500,
    8: 14'd4000,  9: 14'd4500,  10: 14'd5000, 11: 14'd5500,
    12: 14'd6000, 13: 14'd6500, 14: 14'd7000, 15: 14'd7500,
    16: 14'd8000, default: 14'd0
  };

  // Rounded-up reciprocal slopes dy * 2^FRAC / width. With offsets below 128
  // the truncated product equals the exact floor of offset * dy / width.
  localparam logic [SLOPE_W-1:0] SLOPE_ROM [ROM_CAP] = '{
    0: SLOPE_W'((SLOPE_NUM + 53) / 54),  1: SLOPE_W'((SLOPE_NUM + 75) / 76),
    2: SLOPE_W'((SLOPE_NUM + 53) / 54),  3: SLOPE_W'((SLOPE_NUM + 37) / 38),
    4: SLOPE_W'((SLOPE_NUM + 53) / 54),  5: SLOPE_W'((SLOPE_NUM + 65) / 66),
    6: SLOPE_W'((SLOPE_NUM + 37) / 38),  7: SLOPE_W'((SLOPE_NUM + 77) / 78),
    8: SLOPE_W'((SLOPE_NUM + 37) / 38),  9: SLOPE_W'((SLOPE_NUM + 75) / 76),
    10: SLOPE_W'((SLOPE_NUM + 75) / 76), 11: SLOPE_W'((SLOPE_NUM + 29) / 30),
    12: SLOPE_W'((SLOPE_NUM + 81) / 82), 13: SLOPE_W'((SLOPE_NUM + 57) / 58),
    14: SLOPE_W'((SLOPE_NUM + 65) / 66), 15: SLOPE_W'((SLOPE_NUM + 53) / 54),
    default: SLOPE_W'(0)
  };

  // One classified speed on its way from the front to the back.
  typedef struct packed {
    logic             neg;
    logic [SEG_W-1:0] seg;
    logic [DS_W-1:0]  ds;
  } s2d_item_t;

endpackage
`default_nettype wire

// ===== sv/s2d_front.sv =====
// Front of the interpolator: takes the speed magnitude and finds its segment
// and offset with a parallel compare. Depends on s2d_pkg.
`default_nettype none
module s2d_front #(
  parameter int NUM_SEG = 16
) (
  input  wire logic [s2d_pkg::SPEED_W-1:0] speed,
  output s2d_pkg::s2d_item_t               item
);

  logic [s2d_pkg::ABS_W-1:0] mag;
  logic [s2d_pkg::SEG_W-1:0] seg;
  logic [s2d_pkg::ABS_W-1:0] diff;
  logic                      hit_any;

  assign mag = speed[s2d_pkg::SPEED_W-1]
             ? (s2d_pkg::ABS_W'(0) - {speed[s2d_pkg::SPEED_W-1], speed})
             : {1'b0, speed};

  // The points rise, so the compares form a thermometer; the lowest hit wins.
  always_comb begin
    seg     = s2d_pkg::SEG_W'(NUM_SEG);
    hit_any = 1'b0;
    for (int i = NUM_SEG - 1; i >= 0; i--) begin
      if (mag <= s2d_pkg::ABS_W'(s2d_pkg::SPEED_ROM[i+1])) begin
        seg     = s2d_pkg::SEG_W'(i);
        hit_any = 1'b1;
      end
    end
  end

  // Beyond the last point the segment index names the last point itself and
  // a zero offset leaves its duty untouched.
  assign diff = mag - s2d_pkg::ABS_W'(s2d_pkg::SPEED_ROM[seg]);

  assign item.neg = speed[s2d_pkg::SPEED_W-1];
  assign item.seg = seg;
  assign item.ds  = hit_any ? diff[s2d_pkg::DS_W-1:0] : '0;

endmodule
`default_nettype wire

// ===== sv/s2d_queue.sv =====
// Two-entry queue between the front and the back of the interpolator.
// Depends on s2d_pkg for the item type.
`default_nettype none
module s2d_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire s2d_pkg::s2d_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    not_empty,
  output s2d_pkg::s2d_item_t      pop_item
);

  s2d_pkg::s2d_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== sv/s2d_back.sv =====
// Back of the interpolator: slope multiply, then base add, clamp and sign
// into the output register. Depends on s2d_pkg.
`default_nettype none
module s2d_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        item_valid,
  input  wire s2d_pkg::s2d_item_t          item,
  output logic                             item_pop,
  input  wire logic [s2d_pkg::MAG_W-1:0]   limit,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [s2d_pkg::DUTY_W-1:0]       out_duty
);

  logic                         mul_valid_r;
  logic                         mul_neg_r;
  logic [s2d_pkg::PROD_W-1:0]   mul_prod_r;
  logic [s2d_pkg::DUTY_W-1:0]   mul_base_r;
  logic                         out_valid_r;
  logic [s2d_pkg::DUTY_W-1:0]   out_duty_r;
  logic                         out_adv;
  logic                         mul_adv;
  logic [s2d_pkg::Q_W-1:0]      quot;
  logic [s2d_pkg::MAG_W-1:0]    mag;
  logic [s2d_pkg::MAG_W-1:0]    mag_clamped;
  logic [s2d_pkg::DUTY_W-1:0]   duty_nxt;

  assign out_adv  = !out_valid_r || out_ready;
  assign mul_adv  = !mul_valid_r || out_adv;
  assign item_pop = item_valid && mul_adv;

  assign quot        = mul_prod_r[s2d_pkg::PROD_W-1:s2d_pkg::FRAC];
  assign mag         = {1'b0, mul_base_r} + s2d_pkg::MAG_W'(quot);
  assign mag_clamped = (mag > limit) ? limit : mag;
  assign duty_nxt    = mul_neg_r ? (s2d_pkg::DUTY_W'(0) - mag_clamped[s2d_pkg::DUTY_W-1:0])
                                 : mag_clamped[s2d_pkg::DUTY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (mul_adv) begin
        mul_valid_r <= item_valid;
      end
      if (out_adv) begin
        out_valid_r <= mul_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      mul_neg_r  <= item.neg;
      mul_base_r <= s2d_pkg::DUTY_ROM[item.seg];
      mul_prod_r <= s2d_pkg::PROD_W'(item.ds) * s2d_pkg::PROD_W'(s2d_pkg::SLOPE_ROM[item.seg]);
    end
    if (out_adv && mul_valid_r) begin
      out_duty_r <= duty_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_duty  = out_duty_r;

endmodule
`default_nettype wire

// ===== sv/speed_to_duty_interpolator.sv =====
// Top level of the speed-to-duty interpolator: front classifier, queue and
// back datapath, plus the duty limit register. Depends on s2d_pkg.
//
// Maps a signed speed in tenths of a unit to a signed PWM duty by linear
// interpolation over a constant table of up to 17 points, truncating toward
// zero, with the sign restored and the magnitude clamped to duty_limit.
// Speeds beyond the last point give the last duty, also clamped. One
// transaction is taken per clock while the queue is not full; a result passes
// from the front compare, which writes the queue at the accepting edge, to
// the slope multiply, then to the base add and clamp into the output
// register, and the two-entry queue lets the input keep flowing until it fills
// while the output is stalled. duty_limit resets to 10000 and is written
// through the cfg channel, which is always ready.
`default_nettype none
module speed_to_duty_interpolator #(
  parameter int TABLE_POINTS = 17
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] speed_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [13:0] duty_out, [15:14] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [14:0] cfg_data    // [14:0] duty_limit
);

  localparam int NUM_PTS = (TABLE_POINTS > s2d_pkg::ROM_FILLED) ? s2d_pkg::ROM_FILLED
                         : (TABLE_POINTS < 2) ? 2 : TABLE_POINTS;

  logic [s2d_pkg::MAG_W-1:0]  limit_r;
  s2d_pkg::s2d_item_t         front_item;
  s2d_pkg::s2d_item_t         q_item;
  logic                       q_full;
  logic                       q_not_empty;
  logic                       q_pop;
  logic                       push;
  logic [s2d_pkg::DUTY_W-1:0] duty;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= s2d_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  s2d_front #(
    .NUM_SEG (NUM_PTS - 1)
  ) u_front (
    .speed (in_tdata),
    .item  (front_item)
  );

  s2d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_item)
  );

  s2d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_not_empty),
    .item       (q_item),
    .item_pop   (q_pop),
    .limit      (limit_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_duty   (duty)
  );

  assign out_tdata = {2'b00, duty};

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for speed_to_duty_interpolator: streams signed speeds,
// predicts each duty from its own copy of the knee tables and the duty limit,
// and checks every output transaction in order. Depends on the RTL and s2d_pkg.
`default_nettype none
module tb;

  localparam int NUM_POINTS = 17;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AFTER = 400;    // results seen before the long output stall
  localparam int HOLD_CYCLES = 300;

  // Knee points of the speed map, speed in tenths of a unit.
  localparam int KNEE_SPEED [NUM_POINTS] = '{
    0, 54, 130, 184, 222, 276, 342, 380, 458, 496, 572, 648, 678, 760, 818, 884, 938
  };
  localparam int KNEE_DUTY [NUM_POINTS] = '{
    0, 500, 1000, 1500, 2000, 2500, 3000, 3500,
    4000, 4500, 5000, 5500, 6000, 6500, 7000, 7500, 8000
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [14:0] cfg_data = '0;

  logic [15:0] speed_queue [$];
  logic [13:0] duty_expected [$];
  logic [14:0] limit_now = 15'd10000;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          cycle_count = 0;

  speed_to_duty_interpolator #(.TABLE_POINTS(NUM_POINTS)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),      // [15:0] speed_in
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),    // [13:0] duty_out, [15:14] zero
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)       // [14:0] duty_limit
  );

  always #5 clk = ~clk;

  // Interpolated duty for one speed, truncated toward zero, sign restored,
  // magnitude clamped to the limit.
  function automatic logic [13:0] duty_for_speed(input logic [15:0] raw,
                                                 input logic [14:0] lim);
    int sp;
    int s;
    int mag;
    int duty;
    int w;
    int ds;
    bit found;
    sp = $signed(raw);
    if (sp == 0) return 14'd0;
    s = (sp < 0) ? -sp : sp;
    mag = KNEE_DUTY[NUM_POINTS-1];
    found = 1'b0;
    for (int i = 0; i < NUM_POINTS - 1; i++) begin
      if (!found && s <= KNEE_SPEED[i+1]) begin
        w = KNEE_SPEED[i+1] - KNEE_SPEED[i];
        if (w > 0) begin
          ds = s - KNEE_SPEED[i];
          if (ds < 0) ds = 0;
          mag = KNEE_DUTY[i] + (ds * (KNEE_DUTY[i+1] - KNEE_DUTY[i])) / w;
          found = 1'b1;
        end
      end
    end
    if (mag > int'(lim)) mag = int'(lim);
    duty = (sp < 0) ? -mag : mag;
    return duty[13:0];
  endfunction

  function automatic logic [15:0] random_speed();
    int mag;
    int pick;
    logic [15:0] v;
    pick = $urandom_range(0, 9);
    if (pick <= 4) mag = $urandom_range(1, 938);
    else if (pick == 5) mag = KNEE_SPEED[$urandom_range(0, NUM_POINTS-1)] + $urandom_range(0, 2) - 1;
    else if (pick == 6) mag = 0;
    else if (pick == 8) mag = $urandom_range(939, 32767);
    else if (pick == 9) mag = ($urandom_range(0, 1) != 0) ? 32767 : 939;
    if (mag < 0) mag = 0;
    v = mag[15:0];
    if ($urandom_range(0, 1) != 0) v = -v;
    if (pick == 7) v = 16'($urandom_range(0, 65535));
    if (pick == 9 && $urandom_range(0, 3) == 0) v = 16'h8000;
    return v;
  endfunction

  // Driver: holds an offered speed until its transaction completes.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_tready) begin
      in_tvalid <= 1'b1;
    end else begin
      if (in_tvalid) begin
        duty_expected.push_back(duty_for_speed(in_tdata, limit_now));
        void'(speed_queue.pop_front());
      end
      if (speed_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= speed_queue[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long output stall, once, so the block fills up and backs up its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compares each output transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (duty_expected.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected duty %0d with nothing predicted", $signed(out_tdata[13:0]));
          mismatches <= mismatches + 1;
        end else begin
          if (out_tdata[13:0] !== duty_expected[0]) begin
            if (mismatches < 10)
              $display("duty mismatch: expected %0d, got %0d",
                       $signed(duty_expected[0]), $signed(out_tdata[13:0]));
            mismatches <= mismatches + 1;
          end
          void'(duty_expected.pop_front());
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (speed_queue.size() != 0 || in_tvalid || duty_expected.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_limit(input logic [14:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_now = value;
  endtask

  task automatic load_random(input int count);
    for (int i = 0; i < count; i++) speed_queue.push_back(random_speed());
  endtask

  initial begin
    logic [15:0] directed [] = '{
      16'd0, 16'd1, -16'd1, 16'd53, 16'd54, -16'd54, 16'd55, 16'd130,
      16'd500, -16'd500, 16'd678, 16'd679, 16'd818, 16'd884, 16'd937, 16'd938,
      -16'd938, 16'd939, -16'd939, 16'h7FFF, 16'h8001, 16'h8000
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 23;
    recv_idle_pct = 48;
    foreach (directed[i]) speed_queue.push_back(directed[i]);

    write_limit(15'd32767);
    load_random(250);

    write_limit(15'd0);
    load_random(80);

    write_limit(15'd4321);
    send_idle_pct = 48;
    recv_idle_pct = 23;
    load_random(450);

    write_limit(15'd8000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_random(250);

    write_limit(15'($urandom_range(0, 32767)));
    send_idle_pct = 23;
    recv_idle_pct = 48;
    load_random(250);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && duty_expected.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/s2d_pkg.sv
sv/s2d_front.sv
sv/s2d_queue.sv
sv/s2d_back.sv
sv/speed_to_duty_interpolator.sv
tb/tb.sv
